// ----- design/sma_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack machine ALU package
// Shared sizes, instruction codes and status codes of the operand stack.
// ----------------------------------------------------------------------------
package sma_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int WORD_W      = 32;
    localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ITER_W      = $clog2(WORD_W);
    localparam int OUT_CNT_W   = 7;
    localparam int ALU_W       = WORD_W + 2;

    typedef logic [WORD_W-1:0] word_t;

    typedef enum logic [2:0] {
        OP_NOP  = 3'd0,
        OP_PUSH = 3'd1,
        OP_SWAP = 3'd2,
        OP_ADD  = 3'd3,
        OP_SUB  = 3'd4,
        OP_DIV  = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_SHORT   = 2'd1,
        ST_DIVZERO = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

endpackage

// ----- design/stack_machine_alu.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack machine ALU
// Bounded stack of signed 32-bit words driven by nop, push, swap, add, sub
// and div instructions, one status/top/count result per instruction.
// ----------------------------------------------------------------------------
// One instruction is in flight at a time; s_tready is high only while the
// sequencer is idle. Div runs the 32-step restoring division loop, one
// quotient bit per cycle on the single shared 34-bit adder, which also
// serves add, sub and the sign corrections of div. The stack words live in
// a single-write, single-read RAM with registered read; the top entry is
// also held in a register, so only the second entry is ever read. There is
// no clearing pass after reset: entries are only read once written. The
// result sits in an output register, so the next instruction is taken
// while a result still waits for m_tready.
// Statuses: ok, stack too short (checked first), divide by zero, stack full.
// On any error the stack is left unchanged. stack_count is the entry count
// masked to 7 bits; top_value reads 0 on an empty stack.
// ----------------------------------------------------------------------------
module stack_machine_alu (
    input  logic        aclk,
    input  logic        aresetn,
    // Instruction channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] push_value
    input  logic [7:0]  s_tuser,   // [2:0] op
    // Result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] top_value, [38:32] stack_count
    output logic [7:0]  m_tuser    // [1:0] status
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SWAP2,
        S_DEN,
        S_DIV,
        S_FIX,
        S_DONE
    } state_t;

    localparam int ACC_W = sma_pkg::CNT_W + sma_pkg::OUT_CNT_W;

    state_t                        state_reg,  state_next;
    logic [sma_pkg::CNT_W-1:0]     count_reg,  count_next;
    sma_pkg::word_t                top_reg,    top_next;
    sma_pkg::word_t                quo_reg,    quo_next;   // quotient, or scratch word
    sma_pkg::word_t                den_reg,    den_next;
    sma_pkg::word_t                rem_reg,    rem_next;
    logic                          qneg_reg,   qneg_next;
    logic [sma_pkg::ITER_W-1:0]    iter_reg,   iter_next;
    sma_pkg::op_t                  op_reg,     op_next;
    sma_pkg::status_t              status_reg, status_next;

    logic                          m_tvalid_reg, m_tvalid_next;
    sma_pkg::status_t              m_status_reg, m_status_next;
    sma_pkg::word_t                m_top_reg,    m_top_next;
    logic [sma_pkg::OUT_CNT_W-1:0] m_count_reg,  m_count_next;

    // Stack RAM port
    logic                          wr_en;
    logic [sma_pkg::ADDR_W-1:0]    wr_addr;
    sma_pkg::word_t                wr_data;
    sma_pkg::word_t                rd_data;

    // Shared adder
    logic [sma_pkg::ALU_W-1:0]     alu_a, alu_b, alu_sum;
    logic                          alu_sub;
    logic                          borrow;

    logic [sma_pkg::CNT_W-1:0]     top_idx, sec_idx;
    logic [sma_pkg::ADDR_W-1:0]    top_addr, sec_addr, push_addr;
    logic [ACC_W-1:0]              count_ext;
    logic                          out_free;
    logic                          stack_full, stack_short;
    sma_pkg::op_t                  op_in;
    sma_pkg::word_t                shifted_rem;

    assign top_idx    = count_reg - sma_pkg::CNT_W'(1);
    assign sec_idx    = count_reg - sma_pkg::CNT_W'(2);
    assign top_addr   = top_idx[sma_pkg::ADDR_W-1:0];
    assign sec_addr   = sec_idx[sma_pkg::ADDR_W-1:0];
    assign push_addr  = count_reg[sma_pkg::ADDR_W-1:0];
    assign stack_full  = (count_reg == sma_pkg::CNT_W'(sma_pkg::STACK_DEPTH));
    assign stack_short = (count_reg < sma_pkg::CNT_W'(2));
    assign count_ext  = {{sma_pkg::OUT_CNT_W{1'b0}}, count_reg};
    assign out_free   = !m_tvalid_reg || m_tready;
    assign op_in      = sma_pkg::op_t'(s_tuser[2:0]);
    assign s_tready   = (state_reg == S_IDLE);

    // Adder: a + b, or a - b with the borrow in the top bit
    assign alu_sum = alu_a + (alu_sub ? ~alu_b : alu_b) + sma_pkg::ALU_W'(alu_sub);
    assign borrow  = alu_sum[sma_pkg::ALU_W-1];
    assign shifted_rem = {rem_reg[sma_pkg::WORD_W-2:0], quo_reg[sma_pkg::WORD_W-1]};

    sma_ram #(
        .WIDTH (sma_pkg::WORD_W),
        .DEPTH (sma_pkg::STACK_DEPTH)
    ) u_stack_ram (
        .clk     (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (sec_addr),
        .rd_data (rd_data)
    );

    // Adder operand select
    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        unique case (state_reg)
            S_READ: begin
                if (op_reg == sma_pkg::OP_DIV) begin
                    // magnitude of the dividend
                    alu_sub = rd_data[sma_pkg::WORD_W-1];
                    alu_a   = alu_sub ? '0 : {2'b00, rd_data};
                    alu_b   = alu_sub ? {2'b00, rd_data} : '0;
                end else begin
                    alu_sub = (op_reg == sma_pkg::OP_SUB);
                    alu_a   = {2'b00, rd_data};
                    alu_b   = {2'b00, top_reg};
                end
            end
            S_DEN: begin
                // magnitude of the divisor
                alu_sub = top_reg[sma_pkg::WORD_W-1];
                alu_a   = alu_sub ? '0 : {2'b00, top_reg};
                alu_b   = alu_sub ? {2'b00, top_reg} : '0;
            end
            S_DIV: begin
                alu_sub = 1'b1;
                alu_a   = {1'b0, rem_reg, quo_reg[sma_pkg::WORD_W-1]};
                alu_b   = {2'b00, den_reg};
            end
            S_FIX: begin
                // apply the quotient sign
                alu_sub = qneg_reg;
                alu_a   = qneg_reg ? '0 : {2'b00, quo_reg};
                alu_b   = qneg_reg ? {2'b00, quo_reg} : '0;
            end
            default: begin
                alu_sub = 1'b0;
            end
        endcase
    end

    // Sequencer
    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        top_next      = top_reg;
        quo_next      = quo_reg;
        den_next      = den_reg;
        rem_next      = rem_reg;
        qneg_next     = qneg_reg;
        iter_next     = iter_reg;
        op_next       = op_reg;
        status_next   = status_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_status_next = m_status_reg;
        m_top_next    = m_top_reg;
        m_count_next  = m_count_reg;
        wr_en         = 1'b0;
        wr_addr       = sec_addr;
        wr_data       = alu_sum[sma_pkg::WORD_W-1:0];

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next     = op_in;
                    status_next = sma_pkg::ST_OK;
                    state_next  = S_DONE;
                    unique case (op_in)
                        sma_pkg::OP_PUSH: begin
                            if (stack_full) begin
                                status_next = sma_pkg::ST_FULL;
                            end else begin
                                wr_en      = 1'b1;
                                wr_addr    = push_addr;
                                wr_data    = s_tdata;
                                top_next   = s_tdata;
                                count_next = count_reg + sma_pkg::CNT_W'(1);
                            end
                        end
                        sma_pkg::OP_SWAP, sma_pkg::OP_ADD,
                        sma_pkg::OP_SUB, sma_pkg::OP_DIV: begin
                            if (stack_short) begin
                                status_next = sma_pkg::ST_SHORT;
                            end else if (op_in == sma_pkg::OP_DIV && top_reg == '0) begin
                                status_next = sma_pkg::ST_DIVZERO;
                            end else begin
                                // second entry is read at this edge
                                state_next = S_READ;
                            end
                        end
                        default: begin
                            status_next = sma_pkg::ST_OK;
                        end
                    endcase
                end
            end

            S_READ: begin
                unique case (op_reg)
                    sma_pkg::OP_SWAP: begin
                        wr_en      = 1'b1;
                        wr_addr    = top_addr;
                        wr_data    = rd_data;
                        top_next   = rd_data;
                        quo_next   = top_reg;     // old top goes below next cycle
                        state_next = S_SWAP2;
                    end
                    sma_pkg::OP_ADD, sma_pkg::OP_SUB: begin
                        wr_en      = 1'b1;
                        top_next   = alu_sum[sma_pkg::WORD_W-1:0];
                        count_next = top_idx;
                        state_next = S_DONE;
                    end
                    sma_pkg::OP_DIV: begin
                        quo_next   = alu_sum[sma_pkg::WORD_W-1:0];
                        qneg_next  = rd_data[sma_pkg::WORD_W-1] ^ top_reg[sma_pkg::WORD_W-1];
                        state_next = S_DEN;
                    end
                    default: begin
                        state_next = S_DONE;
                    end
                endcase
            end

            S_SWAP2: begin
                wr_en      = 1'b1;
                wr_data    = quo_reg;
                state_next = S_DONE;
            end

            S_DEN: begin
                den_next   = alu_sum[sma_pkg::WORD_W-1:0];
                rem_next   = '0;
                iter_next  = '0;
                state_next = S_DIV;
            end

            S_DIV: begin
                // one restoring step: shift in the next dividend bit
                rem_next  = borrow ? shifted_rem : alu_sum[sma_pkg::WORD_W-1:0];
                quo_next  = {quo_reg[sma_pkg::WORD_W-2:0], !borrow};
                iter_next = iter_reg + sma_pkg::ITER_W'(1);
                if (iter_reg == sma_pkg::ITER_W'(sma_pkg::WORD_W - 1)) begin
                    state_next = S_FIX;
                end
            end

            S_FIX: begin
                wr_en      = 1'b1;
                top_next   = alu_sum[sma_pkg::WORD_W-1:0];
                count_next = top_idx;
                state_next = S_DONE;
            end

            S_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_status_next = status_reg;
                    m_top_next    = (count_reg == '0) ? '0 : top_reg;
                    m_count_next  = count_ext[sma_pkg::OUT_CNT_W-1:0];
                    state_next    = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
            top_reg      <= top_next;
            quo_reg      <= quo_next;
            den_reg      <= den_next;
            rem_reg      <= rem_next;
            qneg_reg     <= qneg_next;
            iter_reg     <= iter_next;
            op_reg       <= op_next;
            status_reg   <= status_next;
            m_status_reg <= m_status_next;
            m_top_reg    <= m_top_next;
            m_count_reg  <= m_count_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, m_count_reg, m_top_reg};
    assign m_tuser  = {6'b0, m_status_reg};

    // Entry count never runs past the stack depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= sma_pkg::CNT_W'(sma_pkg::STACK_DEPTH))
        else $error("entry count beyond stack depth");

    // A transfer in makes the sequencer busy on the next cycle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("instruction accepted while busy");

    // Restoring division keeps the partial remainder below the divisor
    a_rem_below_den: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV) |-> (rem_reg < den_reg))
        else $error("division remainder out of range");

    // An idle RAM write only comes from an accepted push
    a_idle_write_push: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_en && state_reg == S_IDLE) |-> (s_tvalid && op_in == sma_pkg::OP_PUSH))
        else $error("stack write without push");

endmodule

// ----- design/sma_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module sma_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                     clk,
    input  logic                                     wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                         wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
